### src/pair_sum_index_search_top_macros.svh
// assertion macros for the pair sum index search block
// used by files that assert; they expect clk_i and rst_ni in scope
`ifndef PAIR_SUM_INDEX_SEARCH_TOP_MACROS_SVH
`define PAIR_SUM_INDEX_SEARCH_TOP_MACROS_SVH

// plain invariant, checked on every clock edge out of reset
`define PSIS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define PSIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/psis_pkg.sv
// shared types and constants for the pair sum index search block
// no dependencies; imported by psis_seen_mem and the top level
package psis_pkg;

  localparam int ValueW      = 14;
  localparam int TargetW     = 15;
  localparam int PosW        = 11;
  localparam int MaxItemsDef = 1024;
  localparam int ValueSpan   = 1 << ValueW;

  // input word
  typedef struct packed {
    logic [ValueW-1:0] item_value;
    logic              last_item;
  } in_word_t;

  // result word
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] first_position;
    logic [PosW-1:0] second_position;
    logic            overflow;
  } out_word_t;

  // access request to the seen-position table
  typedef struct packed {
    logic              re;
    logic [ValueW-1:0] raddr;
    logic              we;
    logic [ValueW-1:0] waddr;
  } seen_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR_ALL,
    ST_LOAD,
    ST_SCAN,
    ST_RESULT,
    ST_SWEEP
  } state_e;

endpackage

### src/pair_sum_index_search_top.sv
// pair sum index search top level: clear, load, scan, result and table sweep control
// depends on psis_pkg, psis_seen_mem and pair_sum_index_search_top_macros.svh
//
//  channel | dir | handshake                  | word
//  --------+-----+----------------------------+-----------------------------------
//  in      | in  | in_valid_i / in_ready_o    | in_word_i  (item_value, last_item)
//  out     | out | out_valid_o / out_ready_i  | out_word_o (found, positions, overflow)
//  cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_target_sum_i
//
// loading takes one word per cycle; the seen table update is a read-modify-write
// with forwarding for repeated values.
// after the last word the scan steps through up to n stored words, one position per
// cycle, through the value store and the seen table read port.
// the result then goes to the output register and a sweep zeroes the table entries
// that were used; no word is taken during scan and sweep.
// after reset a clearing pass zeroes all 16384 seen table entries before loading.
// a result waiting on out_ready_i stalls only the hand-off of the next result.
`include "pair_sum_index_search_top_macros.svh"

module pair_sum_index_search_top #(
  parameter int MaxItems = psis_pkg::MaxItemsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psis_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psis_pkg::out_word_t           out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psis_pkg::TargetW-1:0]  cfg_target_sum_i
);
  import psis_pkg::*;

  localparam int CntW  = $clog2(MaxItems + 1);
  localparam int AddrW = $clog2(MaxItems);
  localparam int DataW = 2 * CntW;
  localparam int CmpW  = ((ValueW > TargetW) ? ValueW : TargetW) + 1;
  localparam logic [CmpW-1:0] SpanC = CmpW'(ValueSpan);

  state_e               state_q, state_d;
  logic [TargetW-1:0]   target_q;
  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic                 ld1_valid_q;
  logic [ValueW-1:0]    ld1_addr_q;
  logic [CntW-1:0]      ld1_pos_q;
  logic [CntW-1:0]      idx_q;
  logic                 rd1_valid_q;
  logic [CntW-1:0]      rd1_pos_q;
  logic [ValueW-1:0]    val_rd_q;
  logic                 sc2_valid_q;
  logic [CntW-1:0]      sc2_pos_q;
  logic                 sc2_inr_q;
  logic                 sc2_eq_q;
  logic [ValueW-1:0]    clr_q;
  logic                 res_found_q;
  logic [CntW-1:0]      res_p1_q;
  logic [CntW-1:0]      res_p2_q;
  logic                 out_valid_q;
  out_word_t            out_q;

  logic [ValueW-1:0]    val_mem_q [MaxItems];

  seen_req_t            seen_req;
  logic [DataW-1:0]     seen_wdata;
  logic [DataW-1:0]     seen_rdata;
  logic [CntW-1:0]      seen_first;
  logic [CntW-1:0]      seen_second;
  logic [DataW-1:0]     ld_upd;

  logic                 in_fire;
  logic                 store_ok;
  logic                 issue;
  logic                 scan_done;
  logic                 res_load;
  logic [CmpW-1:0]      t_ext, a_ext, diff;
  logic                 comp_inr;
  logic [ValueW-1:0]    comp;
  logic                 comp_eq;
  logic                 match_ne, match_eq, match;
  logic [CntW+PosW-1:0] p1_ext, p2_ext;

  // seen table
  psis_seen_mem #(
    .MaxItems (MaxItems)
  ) u_seen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (seen_req),
    .wdata_i (seen_wdata),
    .rdata_o (seen_rdata)
  );

  assign seen_first  = seen_rdata[DataW-1:CntW];
  assign seen_second = seen_rdata[CntW-1:0];

  // handshake qualifiers
  assign in_fire  = in_valid_i && in_ready_o;
  assign store_ok = count_q < CntW'(MaxItems);
  assign res_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // load update: fill first slot, then second, else keep
  always_comb begin
    if (seen_first == '0) begin
      ld_upd = {ld1_pos_q, {CntW{1'b0}}};
    end else if (seen_second == '0) begin
      ld_upd = {seen_first, ld1_pos_q};
    end else begin
      ld_upd = seen_rdata;
    end
  end

  // complement of the stored value read this cycle
  assign t_ext    = CmpW'(target_q);
  assign a_ext    = CmpW'(val_rd_q);
  assign diff     = t_ext - a_ext;
  assign comp_inr = (t_ext >= a_ext) && (diff < SpanC);
  assign comp     = diff[ValueW-1:0];
  assign comp_eq  = comp == val_rd_q;

  // match check on the seen entry of the complement
  assign match_ne  = sc2_valid_q && sc2_inr_q && !sc2_eq_q && (seen_first != '0);
  assign match_eq  = sc2_valid_q && sc2_inr_q && sc2_eq_q && (seen_second != '0);
  assign match     = (state_q == ST_SCAN) && (match_ne || match_eq);
  assign scan_done = (idx_q == count_q) && !rd1_valid_q && !sc2_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR_ALL: begin
        if (clr_q == {ValueW{1'b1}}) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_fire && in_word_i.last_item) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_load) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if ((idx_q == count_q) && !rd1_valid_q) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_CLEAR_ALL;
      end
    endcase
  end

  // outputs and table access per state
  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b1;
    issue       = 1'b0;
    seen_req    = '0;
    seen_wdata  = '0;
    if (ld1_valid_q) begin
      seen_req.we    = 1'b1;
      seen_req.waddr = ld1_addr_q;
      seen_wdata     = ld_upd;
    end
    case (state_q)
      ST_CLEAR_ALL: begin
        seen_req.we    = 1'b1;
        seen_req.waddr = clr_q;
        seen_wdata     = '0;
      end
      ST_LOAD: begin
        in_ready_o     = 1'b1;
        seen_req.re    = in_fire && store_ok;
        seen_req.raddr = in_word_i.item_value;
      end
      ST_SCAN: begin
        issue          = (idx_q != count_q) && !match;
        seen_req.re    = rd1_valid_q;
        seen_req.raddr = comp;
      end
      ST_SWEEP: begin
        issue = idx_q != count_q;
        if (rd1_valid_q) begin
          seen_req.we    = 1'b1;
          seen_req.waddr = val_rd_q;
          seen_wdata     = '0;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // value store: written at load, read in order by scan and sweep
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_LOAD) && in_fire && store_ok) begin
      val_mem_q[count_q[AddrW-1:0]] <= in_word_i.item_value;
    end
    if (issue) begin
      val_rd_q <= val_mem_q[idx_q[AddrW-1:0]];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    ld1_addr_q <= in_word_i.item_value;
    ld1_pos_q  <= count_q + 1'b1;
    rd1_pos_q  <= idx_q + 1'b1;
    sc2_pos_q  <= rd1_pos_q;
    sc2_inr_q  <= comp_inr;
    sc2_eq_q   <= comp_eq;
    if (state_q == ST_LOAD) begin
      res_p1_q <= '0;
      res_p2_q <= '0;
    end else if (match) begin
      res_p1_q <= match_ne ? sc2_pos_q : seen_first;
      res_p2_q <= match_ne ? seen_first : seen_second;
    end
    if (res_load) begin
      out_q.found           <= res_found_q;
      out_q.first_position  <= p1_ext[PosW-1:0];
      out_q.second_position <= p2_ext[PosW-1:0];
      out_q.overflow        <= ovf_q;
    end
  end

  assign p1_ext = {{PosW{1'b0}}, res_p1_q};
  assign p2_ext = {{PosW{1'b0}}, res_p2_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR_ALL;
      target_q    <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ld1_valid_q <= 1'b0;
      idx_q       <= '0;
      rd1_valid_q <= 1'b0;
      sc2_valid_q <= 1'b0;
      clr_q       <= '0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_target_sum_i;
      end
      // list count and overflow
      if ((state_q == ST_LOAD) && in_fire) begin
        if (store_ok) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if ((state_q == ST_SWEEP) && (state_d == ST_LOAD)) begin
        count_q <= '0;
      end
      if (res_load) begin
        ovf_q <= 1'b0;
      end
      ld1_valid_q <= (state_q == ST_LOAD) && in_fire && store_ok;
      // shared position counter for scan and sweep
      if (state_d != state_q) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      rd1_valid_q <= issue;
      sc2_valid_q <= (state_q == ST_SCAN) && rd1_valid_q && !match;
      if (state_q == ST_CLEAR_ALL) begin
        clr_q <= clr_q + 1'b1;
      end
      // found flag of the pending result
      if (state_q == ST_LOAD) begin
        res_found_q <= 1'b0;
      end else if (match) begin
        res_found_q <= 1'b1;
      end
      // output register
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  `PSIS_ASSERT(a_count_bound, count_q <= CntW'(MaxItems), "item count above capacity")
  `PSIS_ASSERT_NXT(a_last_starts_scan, in_fire && in_word_i.last_item, state_q == ST_SCAN, "last word did not start the scan")
  `PSIS_ASSERT_IMP(a_result_pipe_empty, state_q == ST_RESULT, !rd1_valid_q && !sc2_valid_q, "scan stages busy while result pending")
  `PSIS_ASSERT_IMP(a_notfound_zero, out_valid_q && !out_q.found, (out_q.first_position == '0) && (out_q.second_position == '0), "not-found word carries a position")
  `PSIS_ASSERT(a_no_write_clash, !(ld1_valid_q && (state_q == ST_SWEEP || state_q == ST_CLEAR_ALL)), "load update overlaps table clearing")

endmodule

### src/psis_seen_mem.sv
// seen-position table: first and second position per value, one read and one write port
// depends on psis_pkg; read data is registered, same-cycle write to the read address forwards
module psis_seen_mem #(
  parameter int MaxItems = psis_pkg::MaxItemsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psis_pkg::seen_req_t                  req_i,
  input  logic [2*$clog2(MaxItems+1)-1:0]      wdata_i,
  output logic [2*$clog2(MaxItems+1)-1:0]      rdata_o
);
  import psis_pkg::*;

  localparam int CntW  = $clog2(MaxItems + 1);
  localparam int DataW = 2 * CntW;

  logic [DataW-1:0] mem_q [ValueSpan];
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_hit_q;

  // storage array, write first in code but read returns the old entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
    fwd_data_q <= wdata_i;
  end

  // remember a write that collided with the read of the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= req_i.re && req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule
